// ===== rtl/ats_pkg.sv =====
// Shared types and constants for the additive triangle-wave synthesizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_AMPLITUDE  = 1'b0,
      CSR_PHASE_STEP = 1'b1
   } csr_index_type;

   localparam int SAMPLE_W  = 24;
   localparam int AMP_W     = 16;
   localparam int PHASE_W   = 32;
   localparam int MAG_W     = 39;   // |entry| * amplitude
   localparam int TERM_W    = 40;   // signed weighted harmonic term
   localparam int ACC_W     = 42;   // signed running sum in the tree
   localparam int LANE_LAT  = 6;    // register stages inside one harmonic lane

endpackage
`default_nettype wire

// ===== rtl/ats_harmonic.sv =====
// One harmonic lane: harmonic phase, sine ROM, gain multiply, division by h^2.
// Depends on ats_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ats_harmonic
   import ats_pkg::*;
#(
   parameter int HARMONIC        = 1,
   parameter int SUBTRACT        = 0,
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic                     clock,
   input  wire logic [AMP_W-1:0]         amplitude,
   input  wire logic [PHASE_W-1:0]       phase,
   output logic signed [TERM_W-1:0]      term
);

   localparam int DEPTH = 2 ** SINE_TABLE_BITS;
   localparam int QB    = SINE_TABLE_BITS - 2;
   localparam logic [6:0]  HMULT = 7'(HARMONIC);
   localparam int DIVISOR = HARMONIC * HARMONIC;
   localparam logic [13:0] DIV = 14'(DIVISOR);
   localparam logic [39:0] RECIP = 40'((64'(1) << 39) / DIVISOR);

   function automatic logic signed [63:0] sine_entry(input int j);
      logic signed [63:0] x, x2, p, v;
      int quad, r, xi;
      quad = (j >> QB) & 3;
      r    = j & ((1 << QB) - 1);
      xi   = (quad & 1) != 0 ? ((1 << QB) - r) : r;
      x    = 64'(xi) <<< (30 - QB);
      x2   = (x * x) >>> 30;
      p    = 64'sd172272;
      p    = ((p * x2) >>> 30) - 64'sd5026995;
      p    = ((p * x2) >>> 30) + 64'sd85569306;
      p    = ((p * x2) >>> 30) - 64'sd693598669;
      p    = ((p * x2) >>> 30) + 64'sd1686629713;
      v    = (((p * x) >>> 30) + 64'sd64) >>> 7;
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < 64'sd0) v = 64'sd0;
      return (quad & 2) != 0 ? -v : v;
   endfunction

   function automatic logic [DEPTH*SAMPLE_W-1:0] build_rom();
      logic [DEPTH*SAMPLE_W-1:0] rom;
      logic signed [63:0] e;
      rom = '0;
      for (int j = 0; j < DEPTH; j++) begin
         e = sine_entry(j);
         rom[j*SAMPLE_W +: SAMPLE_W] = e[SAMPLE_W-1:0];
      end
      return rom;
   endfunction

   localparam logic [DEPTH*SAMPLE_W-1:0] SINE_ROM = build_rom();

   logic [PHASE_W-1:0]          hp_ff;
   logic signed [SAMPLE_W-1:0]  entry_ff;
   logic [MAG_W-1:0]            mag3_ff, mag4_ff, mag5_ff;
   logic                        neg3_ff, neg4_ff, neg5_ff;
   logic [39:0]                 pp_ll_ff, pp_lh_ff;
   logic [38:0]                 pp_hl_ff, pp_hh_ff;
   logic [MAG_W-1:0]            q0_ff;
   logic signed [TERM_W-1:0]    term_ff;

   logic [SAMPLE_W-2:0]         entry_mag;
   logic [78:0]                 full_prod;
   logic [52:0]                 qd, rem_val;
   logic [MAG_W-1:0]            q_fix;
   logic [SINE_TABLE_BITS-1:0]  rom_addr;

   assign rom_addr  = hp_ff[PHASE_W-1 -: SINE_TABLE_BITS];
   assign entry_mag = entry_ff[SAMPLE_W-1] ? (SAMPLE_W-1)'(-entry_ff)
                                           : entry_ff[SAMPLE_W-2:0];
   assign full_prod = (79'(pp_hh_ff) << 40) + ((79'(pp_lh_ff) + 79'(pp_hl_ff)) << 20)
                    + 79'(pp_ll_ff);
   assign qd        = 53'(q0_ff) * 53'(DIV);
   assign rem_val   = 53'(mag5_ff) - qd;
   assign q_fix     = q0_ff + MAG_W'(rem_val >= 53'(DIV));

   always_ff @(posedge clock) begin
      hp_ff    <= PHASE_W'(phase * HMULT);
      entry_ff <= SINE_ROM[rom_addr*SAMPLE_W +: SAMPLE_W];
      mag3_ff  <= MAG_W'(entry_mag) * MAG_W'(amplitude);
      neg3_ff  <= entry_ff[SAMPLE_W-1] ^ (SUBTRACT != 0);
      // split the reciprocal multiply into four narrow partial products
      pp_ll_ff <= 40'(mag3_ff[19:0])  * 40'(RECIP[19:0]);
      pp_lh_ff <= 40'(mag3_ff[19:0])  * 40'(RECIP[39:20]);
      pp_hl_ff <= 39'(mag3_ff[38:20]) * 39'(RECIP[19:0]);
      pp_hh_ff <= 39'(mag3_ff[38:20]) * 39'(RECIP[39:20]);
      mag4_ff  <= mag3_ff;
      neg4_ff  <= neg3_ff;
      q0_ff    <= full_prod[77:39];
      mag5_ff  <= mag4_ff;
      neg5_ff  <= neg4_ff;
      // quotient estimate is low by at most one
      term_ff  <= neg5_ff ? -$signed(TERM_W'(q_fix)) : $signed(TERM_W'(q_fix));
   end

   assign term = term_ff;

endmodule
`default_nettype wire

// ===== rtl/ats_sum_tree.sv =====
// Registered adder tree over all harmonic terms, then round and saturate.
// Depends on ats_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ats_sum_tree
   import ats_pkg::*;
#(
   parameter int NUM_TERMS = 50
) (
   input  wire logic                    clock,
   input  wire logic signed [TERM_W-1:0] terms [NUM_TERMS],
   output logic signed [SAMPLE_W-1:0]   sample
);

   localparam int LEVELS = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 0;
   localparam int WIDTH  = 2 ** LEVELS;

   logic signed [ACC_W-1:0] node [LEVELS+1][WIDTH];
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [ACC_W-17:0]   rounded;

   genvar j, l;
   generate
      for (j = 0; j < WIDTH; j++) begin : g_leaf
         if (j < NUM_TERMS) begin : g_used
            assign node[0][j] = ACC_W'(terms[j]);
         end else begin : g_pad
            assign node[0][j] = '0;
         end
      end
      for (l = 1; l <= LEVELS; l++) begin : g_level
         for (j = 0; j < WIDTH; j++) begin : g_node
            if (j < (WIDTH >> l)) begin : g_add
               always_ff @(posedge clock) begin
                  node[l][j] <= node[l-1][2*j] + node[l-1][2*j+1];
               end
            end else begin : g_zero
               assign node[l][j] = '0;
            end
         end
      end
   endgenerate

   assign rounded = (ACC_W-16)'((node[LEVELS][0] + ACC_W'(32768)) >>> 16);

   always_ff @(posedge clock) begin
      if (rounded > (ACC_W-16)'(8388607)) begin
         sample_ff <= SAMPLE_W'(8388607);
      end else if (rounded < -(ACC_W-16)'(8388608)) begin
         sample_ff <= -SAMPLE_W'(8388608);
      end else begin
         sample_ff <= rounded[SAMPLE_W-1:0];
      end
   end

   assign sample = sample_ff;

endmodule
`default_nettype wire

// ===== rtl/additive_triangle_wave_synth.sv =====
// Top level of the additive triangle-wave synthesizer.
// Depends on ats_pkg, ats_harmonic and ats_sum_tree.
`timescale 1ns / 1ps
`default_nettype none
// One transaction takes a frame index and returns one Q1.23 triangle sample
// summed from NUM_HARMONICS odd harmonics. busy never rises: a new index is
// taken every cycle. Each result appears on rsp_sample for one cycle with
// rsp_valid high, after the registered phase multiply, the six stages of
// each harmonic lane, the registered levels of the adder tree and its
// round-and-saturate register. The receiver cannot stall, so capture every
// strobe. Write the CSRs only while no transaction is in flight.
module additive_triangle_wave_synth
   import ats_pkg::*;
#(
   parameter int NUM_HARMONICS   = 50,
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [PHASE_W-1:0]     req_sample_index,
   output logic                        rsp_valid,
   output logic signed [SAMPLE_W-1:0]  rsp_sample,
   input  wire logic                   csr_we,
   input  wire logic [0:0]             csr_index,
   input  wire logic [PHASE_W-1:0]     csr_wdata
);

   localparam int LEVELS = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 0;
   localparam int TOTAL  = 1 + LANE_LAT + LEVELS + 1;

   logic [AMP_W-1:0]   amplitude_ff;
   logic [PHASE_W-1:0] phase_step_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [TOTAL-1:0]   valid_ff;
   logic signed [TERM_W-1:0] terms [NUM_HARMONICS];

   // CSR writes; an index outside the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff  <= AMP_W'(16384);
         phase_step_ff <= PHASE_W'(24347887);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[AMP_W-1:0];
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fundamental phase, modulo one turn
   always_ff @(posedge clock) begin
      phase_ff <= PHASE_W'(req_sample_index * phase_step_ff);
   end

   // advance the valid bit alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[TOTAL-2:0], start & ~busy};
      end
   end

   genvar k;
   generate
      for (k = 0; k < NUM_HARMONICS; k++) begin : g_lane
         ats_harmonic #(
            .HARMONIC        (2 * k + 1),
            .SUBTRACT        (k % 2),
            .SINE_TABLE_BITS (SINE_TABLE_BITS)
         ) u_harmonic (
            .clock     (clock),
            .amplitude (amplitude_ff),
            .phase     (phase_ff),
            .term      (terms[k])
         );
      end
   endgenerate

   ats_sum_tree #(
      .NUM_TERMS (NUM_HARMONICS)
   ) u_sum_tree (
      .clock  (clock),
      .terms  (terms),
      .sample (rsp_sample)
   );

   assign busy      = 1'b0;
   assign rsp_valid = valid_ff[TOTAL-1];

endmodule
`default_nettype wire
